[hdl/soha_pkg.sv]
// Shared constants, codes and types of the size-ordered heap allocator.
package soha_pkg;

    localparam int HEAP_BYTES     = 4096;
    localparam int ALIGN_BYTES    = 8;
    localparam int ALIGN_SHIFT    = $clog2(ALIGN_BYTES);
    localparam int HEADER_BYTES   = 8;
    localparam int FREE_ENTRIES   = 64;
    localparam int ADJUSTED_BYTES = HEAP_BYTES - ALIGN_BYTES;
    localparam int MIN_SPLIT      = HEADER_BYTES * 2;
    localparam int HDR_DEPTH      = HEAP_BYTES / ALIGN_BYTES;
    localparam int HDR_IDX_W      = $clog2(HDR_DEPTH);

    localparam int ADDR_W   = 12;
    localparam int REQ_W    = 16;
    localparam int STATUS_W = 3;
    localparam int WANT_W   = REQ_W + 1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] size;
    } entry_t;

endpackage

[hdl/size_ordered_heap_allocator.sv]
// Top level of the size-ordered heap allocator: sequencer, free table and header store.
//
// Usage: one request enters on the s_ channel (kind, request_bytes, block_address) and
// exactly one result leaves on the m_ channel (status, address, free_bytes). Both
// channels use valid/ready; s_ready is high only while the sequencer is idle, so the
// block works on one request at a time.
// An allocate request scans the free table for a fitting block, moves each entry behind
// the chosen block down one place as that block leaves the table and, when the block is
// split, moves entries up one place to put the remainder back. Scanning and moving down
// together cover the table once. A free request reads the block's header and moves
// entries up one place to insert the freed block. Requests rejected on their size, null
// frees and frees into a full table go from idle straight to S_DONE; an allocation that
// finds no fitting block goes to S_DONE once the scan has passed every entry. Every
// compare and every move passes through the single read port and single write port of
// the free-table memory, one entry per cycle. The result sits in an output register, so
// the block can return to idle and take the next request while the receiver stalls; a
// further result then waits until the held one is taken. After reset the block writes
// the whole-heap entry into the free table in S_INIT and only then raises s_ready. The
// header store is not cleared.
module size_ordered_heap_allocator #(
    parameter int FREE_ENTRIES = soha_pkg::FREE_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [soha_pkg::REQ_W-1:0]        s_request_bytes,
    input  logic [soha_pkg::ADDR_W-1:0]       s_block_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [soha_pkg::STATUS_W-1:0]     m_status,
    output logic [soha_pkg::ADDR_W-1:0]       m_address,
    output logic [soha_pkg::ADDR_W-1:0]       m_free_bytes
);

    localparam int IDX_W = $clog2(FREE_ENTRIES);
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int AW    = soha_pkg::ADDR_W;
    localparam int WW    = soha_pkg::WANT_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FIND, S_REMOVE, S_REM_END, S_HDR_RD, S_INS, S_INS_PUT, S_DONE
    } state_t;

    // Free table and header store: one write and one registered read each.
    soha_pkg::entry_t                  table_mem [FREE_ENTRIES];
    logic [AW-1:0]                     hdr_mem   [soha_pkg::HDR_DEPTH];

    soha_pkg::entry_t                  rd_data_reg;
    logic [AW-1:0]                     hdr_data_reg;

    logic [IDX_W-1:0]                  rd_addr;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_addr;
    soha_pkg::entry_t                  wr_data;
    logic [soha_pkg::HDR_IDX_W-1:0]    hdr_rd_addr;
    logic                              hdr_wr_en;
    logic [soha_pkg::HDR_IDX_W-1:0]    hdr_wr_addr;
    logic [AW-1:0]                     hdr_wr_data;

    state_t                            state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic [IDX_W-1:0]                  pos_reg, pos_next;
    logic [AW-1:0]                     br_reg, br_next;
    logic [AW-1:0]                     want_reg, want_next;
    logic [AW-1:0]                     off_reg, off_next;
    logic [AW-1:0]                     size_reg, size_next;
    logic                              split_reg, split_next;
    logic [soha_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [AW-1:0]                     res_addr_reg, res_addr_next;
    logic                              m_valid_reg, m_valid_next;
    logic [soha_pkg::STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [AW-1:0]                     m_address_reg, m_address_next;
    logic [AW-1:0]                     m_free_reg, m_free_next;

    logic [WW-1:0]                     wanted_full;
    logic [AW-1:0]                     free_off;
    logic [AW:0]                       br_sum;
    logic [AW-1:0]                     used_bytes;
    logic [AW-1:0]                     remainder;
    logic [CNT_W-1:0]                  cnt_after;
    soha_pkg::entry_t                  new_entry;

    // Request plus header, rounded up to the alignment.
    assign wanted_full = (WW'(s_request_bytes)
                          + WW'(soha_pkg::HEADER_BYTES + soha_pkg::ALIGN_BYTES - 1))
                         & ~WW'(soha_pkg::ALIGN_BYTES - 1);
    assign free_off    = s_block_address - AW'(soha_pkg::HEADER_BYTES);
    assign remainder   = rd_data_reg.size - want_reg;
    assign used_bytes  = AW'(soha_pkg::ADJUSTED_BYTES) - br_reg;
    assign br_sum      = {1'b0, br_reg} + {1'b0, hdr_data_reg};
    assign cnt_after   = count_reg - CNT_W'(1);
    assign new_entry   = '{offset: off_reg, size: size_reg};

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_address    = m_address_reg;
    assign m_free_bytes = m_free_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        br_next         = br_reg;
        want_next       = want_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        split_next      = split_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_address_next  = m_address_reg;
        m_free_next     = m_free_reg;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_entry;
        hdr_rd_addr     = free_off[soha_pkg::ALIGN_SHIFT +: soha_pkg::HDR_IDX_W];
        hdr_wr_en       = 1'b0;
        hdr_wr_addr     = rd_data_reg.offset[soha_pkg::ALIGN_SHIFT +: soha_pkg::HDR_IDX_W];
        hdr_wr_data     = rd_data_reg.size;

        case (state_reg)
            S_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{offset: '0, size: AW'(soha_pkg::ADJUSTED_BYTES)};
                state_next = S_IDLE;
            end
            S_IDLE: begin
                res_addr_next = '0;
                if (s_valid) begin
                    if (s_kind == soha_pkg::KIND_ALLOC) begin
                        if (s_request_bytes == '0
                            || wanted_full >= WW'(soha_pkg::ADJUSTED_BYTES)) begin
                            res_status_next = soha_pkg::ST_BAD_SIZE;
                            state_next      = S_DONE;
                        end else begin
                            want_next  = wanted_full[AW-1:0];
                            idx_next   = '0;
                            rd_addr    = '0;
                            state_next = S_FIND;
                        end
                    end else if (s_block_address < AW'(soha_pkg::HEADER_BYTES)) begin
                        res_status_next = soha_pkg::ST_FREED;
                        state_next      = S_DONE;
                    end else if (count_reg == CNT_W'(FREE_ENTRIES)) begin
                        res_status_next = soha_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        off_next        = free_off;
                        res_status_next = soha_pkg::ST_FREED;
                        state_next      = S_HDR_RD;
                    end
                end
            end
            S_FIND: begin
                if (idx_reg >= count_reg) begin
                    res_status_next = soha_pkg::ST_NO_FIT;
                    state_next      = S_DONE;
                end else if (rd_data_reg.size >= want_reg) begin
                    split_next      = (remainder > AW'(soha_pkg::MIN_SPLIT));
                    off_next        = rd_data_reg.offset + want_reg;
                    size_next       = remainder;
                    hdr_wr_en       = 1'b1;
                    hdr_wr_data     = (remainder > AW'(soha_pkg::MIN_SPLIT))
                                      ? want_reg : rd_data_reg.size;
                    br_next         = (br_reg >= hdr_wr_data) ? br_reg - hdr_wr_data : '0;
                    res_status_next = soha_pkg::ST_ALLOCATED;
                    res_addr_next   = rd_data_reg.offset + AW'(soha_pkg::HEADER_BYTES);
                    idx_next        = idx_reg + CNT_W'(1);
                    rd_addr         = IDX_W'(idx_reg + CNT_W'(1));
                    state_next      = (idx_reg + CNT_W'(1) < count_reg) ? S_REMOVE : S_REM_END;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                    rd_addr  = IDX_W'(idx_reg + CNT_W'(1));
                end
            end
            S_REMOVE: begin
                wr_en    = 1'b1;
                wr_addr  = IDX_W'(idx_reg - CNT_W'(1));
                wr_data  = rd_data_reg;
                idx_next = idx_reg + CNT_W'(1);
                rd_addr  = IDX_W'(idx_reg + CNT_W'(1));
                if (idx_reg + CNT_W'(1) >= count_reg) begin
                    state_next = S_REM_END;
                end
            end
            S_REM_END: begin
                count_next = cnt_after;
                if (!split_reg) begin
                    state_next = S_DONE;
                end else if (cnt_after == '0) begin
                    pos_next   = '0;
                    state_next = S_INS_PUT;
                end else begin
                    idx_next   = cnt_after - CNT_W'(1);
                    rd_addr    = IDX_W'(cnt_after - CNT_W'(1));
                    state_next = S_INS;
                end
            end
            S_HDR_RD: begin
                size_next = hdr_data_reg;
                if (hdr_data_reg >= used_bytes) begin
                    br_next = AW'(soha_pkg::ADJUSTED_BYTES);
                end else begin
                    br_next = br_sum[AW-1:0];
                end
                if (count_reg == '0) begin
                    pos_next   = '0;
                    state_next = S_INS_PUT;
                end else begin
                    idx_next   = cnt_after;
                    rd_addr    = IDX_W'(cnt_after);
                    state_next = S_INS;
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(idx_reg + CNT_W'(1));
                // Entries not smaller than the new block move up one place.
                if (rd_data_reg.size >= size_reg) begin
                    wr_data = rd_data_reg;
                    if (idx_reg == '0) begin
                        pos_next   = '0;
                        state_next = S_INS_PUT;
                    end else begin
                        idx_next = idx_reg - CNT_W'(1);
                        rd_addr  = IDX_W'(idx_reg - CNT_W'(1));
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_INS_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_address_next = res_addr_reg;
                    m_free_next    = br_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            count_reg   <= CNT_W'(1);
            br_reg      <= AW'(soha_pkg::ADJUSTED_BYTES);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            br_reg      <= br_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        want_reg       <= want_next;
        off_reg        <= off_next;
        size_reg       <= size_next;
        split_reg      <= split_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_address_reg  <= m_address_next;
        m_free_reg     <= m_free_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (hdr_wr_en) begin
            hdr_mem[hdr_wr_addr] <= hdr_wr_data;
        end
        hdr_data_reg <= hdr_mem[hdr_rd_addr];
    end

endmodule

[hdl/soha_checker.sv]
// Port-level checker for the size-ordered heap allocator, bound to the top level.
module soha_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [soha_pkg::STATUS_W-1:0]     m_status,
    input logic [soha_pkg::ADDR_W-1:0]       m_address,
    input logic [soha_pkg::ADDR_W-1:0]       m_free_bytes
);

    // The block takes one request at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous request still in progress");

    // Only a successful allocation carries an address.
    a_addr_only_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != soha_pkg::ST_ALLOCATED |-> m_address == '0)
        else $error("address given on a result that allocated nothing");

    // Status codes and free byte count stay within their ranges.
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= soha_pkg::ST_TABLE_FULL
                    && m_free_bytes <= soha_pkg::ADJUSTED_BYTES)
        else $error("result status or free byte count out of range");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_address)
                               && $stable(m_free_bytes))
        else $error("result changed while stalled");

endmodule

bind size_ordered_heap_allocator soha_checker u_soha_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_address    (m_address),
    .m_free_bytes (m_free_bytes)
);
